// ----- design/tfm_pkg.sv -----
// Shared types and constants for the topic filter wildcard match unit.
// Used by the input channel interface, the top level and the testbench; depends on nothing.
`default_nettype none

package tfm_pkg;

    // Default capacity of the filter store, in bytes.
    localparam int FILTER_MAX_DEFAULT = 64;

    // Command codes carried by an input transfer.
    typedef enum logic [1:0] {
        CMD_FILTER_BYTE = 2'd0,
        CMD_END_FILTER  = 2'd1,
        CMD_TOPIC_BYTE  = 2'd2,
        CMD_END_TOPIC   = 2'd3
    } cmd_t;

    // Characters with a meaning in topic filters.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

endpackage

`default_nettype wire

// ----- design/tfm_in_if.sv -----
// Input channel of the topic filter wildcard match unit: command and character.
// Depends on tfm_pkg for the command type.
`default_nettype none

interface tfm_in_if;

    logic          valid;
    logic          ready;
    tfm_pkg::cmd_t cmd;
    logic [7:0]    ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink   (input valid, input cmd, input ch, output ready);

endinterface

`default_nettype wire

// ----- design/tfm_out_if.sv -----
// Result channel of the topic filter wildcard match unit: match and overflow flags.
// Self-contained; no package items are needed.
`default_nettype none

interface tfm_out_if;

    logic valid;
    logic ready;
    logic matched;
    logic filter_overflow;

    modport source (output valid, output matched, output filter_overflow, input ready);
    modport sink   (input valid, input matched, input filter_overflow, output ready);

endinterface

`default_nettype wire

// ----- design/topic_filter_wildcard_match_unit.sv -----
// Top level of the topic filter wildcard match unit: filter store, level matcher
// and a two-entry result buffer. Depends on tfm_pkg, tfm_in_if and tfm_out_if.
`default_nettype none

// Channel  | Direction | Payload                    | Transfer
// ---------+-----------+----------------------------+------------------------------
// item     | in        | cmd[1:0], ch[7:0]          | item.valid && item.ready
// result   | out       | matched, filter_overflow   | result.valid && result.ready
//
// One item per cycle is sustained while the result buffer has room.
// The result of an end-topic transfer is registered into the result buffer.
// The matcher keeps a three-byte window of the filter at its cursor, read from
// the two read ports of the filter store at the next cursor, so it is ready for the next command.
// Reset clears all control state at once; the filter store is not cleared.
// item.ready drops only when both result buffer entries are full and waiting.

module topic_filter_wildcard_match_unit #(
    parameter int FILTER_MAX = tfm_pkg::FILTER_MAX_DEFAULT
) (
    input  wire      clk,
    input  wire      rst_n,
    tfm_in_if.sink   item,
    tfm_out_if.source result
);

    // Cursor and length run from zero up to FILTER_MAX inclusive.
    localparam int CW = $clog2(FILTER_MAX + 1);
    localparam int AW = $clog2(FILTER_MAX);
    // Entry i of the store holds filter bytes i and i+1. The last filter byte
    // lives in last_reg, so FILTER_MAX-1 entries cover a full filter.
    localparam int MEM_DEPTH = FILTER_MAX - 1;
    localparam logic [CW-1:0] LEN_MAX   = CW'(FILTER_MAX);
    localparam logic [CW-1:0] DEPTH_CW  = CW'(MEM_DEPTH);
    localparam logic [CW:0]   DEPTH_CW1 = (CW + 1)'(MEM_DEPTH);

    // LEVEL means a filter level has just been entered but not yet classified;
    // it is resolved against the window when the next command arrives.
    typedef enum logic [2:0] {
        MODE_LEVEL,
        MODE_COMPARE,
        MODE_PLUS,
        MODE_ALL,
        MODE_FAIL
    } mode_t;

    logic [15:0]   store_mem [0:MEM_DEPTH-1];
    logic [15:0]   rd_a_reg;
    logic [15:0]   rd_b_reg;
    logic [7:0]    last_reg;
    logic [7:0]    last_next;

    logic [CW-1:0] len_reg;
    logic [CW-1:0] len_next;
    logic [CW-1:0] cursor_reg;
    logic [CW-1:0] cursor_next;
    mode_t         mode_reg;
    mode_t         mode_next;
    logic          overflow_reg;
    logic          overflow_next;
    logic          closed_reg;
    logic          closed_next;

    logic          out_valid_reg;
    logic          out_matched_reg;
    logic          out_ovf_reg;
    logic          skid_valid_reg;
    logic          skid_matched_reg;
    logic          skid_ovf_reg;

    logic          in_xfer;
    logic          pop;
    logic          push;
    logic          push_matched;
    logic          push_ovf;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [CW-1:0] base_len;

    logic [CW:0]   len_ext;
    logic [CW:0]   c1;
    logic [CW:0]   c2;
    logic [CW:0]   c3;
    logic          v0;
    logic          v1;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic [7:0]    b2;
    logic          cls_all;
    logic          cls_plus;

    mode_t         eff_mode;
    logic          eff_shift;
    logic [CW-1:0] e_cur;
    logic [CW-1:0] e_next;
    logic [7:0]    e0;
    logic [7:0]    e1;
    logic          ev0;
    logic          e_len2;
    logic          end_hit;

    logic [CW:0]   rd_b_addr;
    logic          rd_a_in;
    logic          rd_b_in;

    assign in_xfer    = item.valid && item.ready;
    assign pop        = out_valid_reg && result.ready;
    assign item.ready = !skid_valid_reg;

    assign result.valid           = out_valid_reg;
    assign result.matched         = out_matched_reg;
    assign result.filter_overflow = out_ovf_reg;

    // Window of filter bytes at the cursor, with their in-range flags.
    assign len_ext = {1'b0, len_reg};
    assign c1      = {1'b0, cursor_reg} + (CW + 1)'(1);
    assign c2      = {1'b0, cursor_reg} + (CW + 1)'(2);
    assign c3      = {1'b0, cursor_reg} + (CW + 1)'(3);
    assign v0      = cursor_reg < len_reg;
    assign v1      = c1 < len_ext;
    assign b0      = (c1 == len_ext) ? last_reg : rd_a_reg[15:8];
    assign b1      = rd_a_reg[7:0];
    assign b2      = rd_b_reg[7:0];

    // A '#' that is the whole last level, or a '+' that is a whole level.
    assign cls_all  = v0 && !v1 && (b0 == tfm_pkg::CH_HASH);
    assign cls_plus = v0 && (b0 == tfm_pkg::CH_PLUS) && (!v1 || (b1 == tfm_pkg::CH_SLASH));

    // Resolve a pending level start; a '+' level steps the cursor over the '+'.
    always_comb
    begin
        eff_mode  = mode_reg;
        eff_shift = 1'b0;
        if (mode_reg == MODE_LEVEL)
        begin
            if (cls_all)
            begin
                eff_mode = MODE_ALL;
            end
            else if (cls_plus)
            begin
                eff_mode  = MODE_PLUS;
                eff_shift = 1'b1;
            end
            else
            begin
                eff_mode = MODE_COMPARE;
            end
        end
    end

    assign e_cur  = eff_shift ? CW'(c1) : cursor_reg;
    assign e0     = eff_shift ? b1 : b0;
    assign e1     = eff_shift ? b2 : b1;
    assign ev0    = eff_shift ? v1 : v0;
    assign e_len2 = eff_shift ? (c3 == len_ext) : (c2 == len_ext);
    assign e_next = CW'({1'b0, e_cur} + (CW + 1)'(1));

    // The topic ends cleanly when the filter is used up, or when only "/#" is left.
    always_comb
    begin
        case (eff_mode)
            MODE_ALL:  end_hit = 1'b1;
            MODE_FAIL: end_hit = 1'b0;
            default:   end_hit = !ev0 || ((e0 == tfm_pkg::CH_SLASH) &&
                                          (e1 == tfm_pkg::CH_HASH) && e_len2);
        endcase
    end

    assign base_len = closed_reg ? '0 : len_reg;

    always_comb
    begin
        len_next      = len_reg;
        cursor_next   = cursor_reg;
        mode_next     = mode_reg;
        overflow_next = overflow_reg;
        closed_next   = closed_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_addr       = AW'(base_len - CW'(1));
        wr_data       = {last_reg, item.ch};
        push          = 1'b0;
        push_matched  = 1'b0;
        push_ovf      = overflow_reg;
        if (in_xfer)
        begin
            case (item.cmd)
                tfm_pkg::CMD_FILTER_BYTE:
                begin
                    // A filter byte after the close starts a new filter.
                    if (closed_reg)
                    begin
                        overflow_next = 1'b0;
                    end
                    if (base_len < LEN_MAX)
                    begin
                        // The previous byte's entry is completed by this byte.
                        wr_en     = (base_len != '0);
                        last_next = item.ch;
                        len_next  = base_len + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    closed_next = 1'b0;
                    cursor_next = '0;
                    mode_next   = MODE_LEVEL;
                end
                tfm_pkg::CMD_END_FILTER:
                begin
                    closed_next = 1'b1;
                    cursor_next = '0;
                    mode_next   = MODE_LEVEL;
                end
                tfm_pkg::CMD_TOPIC_BYTE:
                begin
                    if (closed_reg)
                    begin
                        if (eff_mode inside {MODE_ALL, MODE_FAIL})
                        begin
                            mode_next = eff_mode;
                        end
                        else if (item.ch == tfm_pkg::CH_SLASH)
                        begin
                            // The topic level ended; the filter level must end too.
                            if (ev0 && (e0 == tfm_pkg::CH_SLASH))
                            begin
                                cursor_next = e_next;
                                mode_next   = MODE_LEVEL;
                            end
                            else
                            begin
                                mode_next = MODE_FAIL;
                            end
                        end
                        else if (eff_mode == MODE_PLUS)
                        begin
                            cursor_next = e_cur;
                            mode_next   = MODE_PLUS;
                        end
                        else if (ev0 && (e0 == item.ch))
                        begin
                            cursor_next = e_next;
                            mode_next   = MODE_COMPARE;
                        end
                        else
                        begin
                            mode_next = MODE_FAIL;
                        end
                    end
                end
                tfm_pkg::CMD_END_TOPIC:
                begin
                    push         = 1'b1;
                    push_matched = closed_reg && !overflow_reg && end_hit;
                    if (closed_reg)
                    begin
                        cursor_next = '0;
                        mode_next   = MODE_LEVEL;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // The store is read at the next cursor so that the window lines up with it.
    assign rd_b_addr = {1'b0, cursor_next} + (CW + 1)'(1);
    assign rd_a_in   = cursor_next < DEPTH_CW;
    assign rd_b_in   = rd_b_addr < DEPTH_CW1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (CW'(wr_addr) == cursor_next))
        begin
            rd_a_reg <= wr_data;
        end
        else if (rd_a_in)
        begin
            rd_a_reg <= store_mem[cursor_next[AW-1:0]];
        end
        if (wr_en && ((CW + 1)'(wr_addr) == rd_b_addr))
        begin
            rd_b_reg <= wr_data;
        end
        else if (rd_b_in)
        begin
            rd_b_reg <= store_mem[rd_b_addr[AW-1:0]];
        end
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            cursor_reg       <= '0;
            mode_reg         <= MODE_LEVEL;
            overflow_reg     <= 1'b0;
            closed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_matched_reg  <= 1'b0;
            out_ovf_reg      <= 1'b0;
            skid_valid_reg   <= 1'b0;
            skid_matched_reg <= 1'b0;
            skid_ovf_reg     <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            cursor_reg   <= cursor_next;
            mode_reg     <= mode_next;
            overflow_reg <= overflow_next;
            closed_reg   <= closed_next;
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_matched_reg <= skid_matched_reg;
                    out_ovf_reg     <= skid_ovf_reg;
                    skid_valid_reg  <= 1'b0;
                end
                else
                begin
                    out_valid_reg   <= push;
                    out_matched_reg <= push_matched;
                    out_ovf_reg     <= push_ovf;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    out_matched_reg <= push_matched;
                    out_ovf_reg     <= push_ovf;
                end
                else
                begin
                    skid_valid_reg   <= 1'b1;
                    skid_matched_reg <= push_matched;
                    skid_ovf_reg     <= push_ovf;
                end
            end
        end
    end

    // The skid entry is only ever filled behind a waiting main entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the main entry is empty");

    // The matcher never walks past the end of the stored filter.
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= len_reg)
        else $error("filter cursor beyond filter length");

    // Overflow is flagged only once the store is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (len_reg == LEN_MAX))
        else $error("overflow flagged with room left in the filter store");

    // An overflowed filter never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> !out_matched_reg)
        else $error("match reported for an overflowed filter");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for topic_filter_wildcard_match_unit: directed table, then random
// filter/topic sessions, checked against typed verdicts or an in-bench MQTT match predictor.
// Depends on tfm_pkg, tfm_in_if, tfm_out_if and the top level of the unit.
`timescale 1ns / 100ps

module tb;

    localparam int FMAX        = tfm_pkg::FILTER_MAX_DEFAULT;
    localparam int RAND_ITEMS  = 670;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;
    localparam int DIR_ROWS    = 39;

    // Progress of one topic through the stored filter.
    typedef enum logic [1:0] {
        LVL_COMPARE,
        LVL_PLUS,
        LVL_ALL,
        LVL_FAIL
    } level_mode_t;

    // One row of the directed table. An expected verdict is typed in only where it is
    // obvious; every other end-topic row is scored by the predictor.
    typedef struct packed {
        tfm_pkg::cmd_t cmd;
        logic [7:0]    ch;
        logic [7:0]    reps;
        bit            typed;
        bit            t_matched;
        bit            t_overflow;
    } step_row_t;

    // One queued input transfer, tagged with the idling phase it belongs to.
    typedef struct packed {
        tfm_pkg::cmd_t cmd;
        logic [7:0]    ch;
        bit            typed;
        bit            t_matched;
        bit            t_overflow;
        logic [1:0]    phase;
    } offer_t;

    typedef struct packed {
        bit matched;
        bit filter_overflow;
    } verdict_t;

    logic clk;
    logic rst_n;

    tfm_in_if  item ();
    tfm_out_if result ();

    topic_filter_wildcard_match_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the filter and the matcher.
    // ------------------------------------------------------------------
    logic [7:0]  flt_bytes [FMAX + 1];
    int unsigned flt_len;
    int unsigned flt_cur;
    level_mode_t lvl_mode;
    bit          lvl_start;
    bit          flt_ovf;
    bit          flt_closed;

    offer_t     offers [$];
    verdict_t   pending_verdicts [$];
    logic [7:0] flt_draft [$];
    logic [7:0] topic_draft [$];

    offer_t cur_offer;
    int     gen_phase;
    int     idle_phase;
    int     last_phase;
    int     hold_left;
    int     quiet_cycles;
    int     err_count;
    int     n_items;
    int     n_results;
    int     n_matches;
    int     n_overflows;

    // Classify the filter level that starts at the cursor.
    function automatic void open_level();
        int unsigned c;
        c = flt_cur;
        lvl_start = 1'b1;
        if (c < flt_len && c + 1 == flt_len && flt_bytes[c] == tfm_pkg::CH_HASH)
            lvl_mode = LVL_ALL;
        else if (c < flt_len && flt_bytes[c] == tfm_pkg::CH_PLUS &&
                 (c + 1 == flt_len || flt_bytes[c + 1] == tfm_pkg::CH_SLASH))
        begin
            lvl_mode = LVL_PLUS;
            flt_cur  = c + 1;
        end
        else
            lvl_mode = LVL_COMPARE;
    endfunction

    function automatic void restart_match();
        flt_cur = 0;
        open_level();
    endfunction

    function automatic void take_topic_byte(logic [7:0] b);
        int unsigned c;
        c = flt_cur;
        if (lvl_mode == LVL_ALL || lvl_mode == LVL_FAIL)
            return;
        if (b == tfm_pkg::CH_SLASH)
        begin
            // A topic level ends; the filter level has to end here as well.
            if (c < flt_len && flt_bytes[c] == tfm_pkg::CH_SLASH)
            begin
                flt_cur = c + 1;
                open_level();
            end
            else
                lvl_mode = LVL_FAIL;
        end
        else if (lvl_mode == LVL_PLUS)
            lvl_start = 1'b0;
        else if (c < flt_len && flt_bytes[c] == b)
        begin
            flt_cur   = c + 1;
            lvl_start = 1'b0;
        end
        else
            lvl_mode = LVL_FAIL;
    endfunction

    function automatic bit topic_matches();
        int unsigned c;
        c = flt_cur;
        if (lvl_mode == LVL_ALL)
            return 1'b1;
        if (lvl_mode == LVL_FAIL)
            return 1'b0;
        if (c >= flt_len)
            return 1'b1;
        // A trailing "/#" also covers its parent topic.
        return flt_bytes[c] == tfm_pkg::CH_SLASH && c + 2 == flt_len &&
               flt_bytes[c + 1] == tfm_pkg::CH_HASH;
    endfunction

    // Advance the predictor by one accepted transfer; has_verdict is set on end topic.
    function automatic void match_step(tfm_pkg::cmd_t cmd, logic [7:0] b,
                                       output bit has_verdict, output verdict_t v);
        has_verdict = 1'b0;
        v           = '0;
        case (cmd)
            tfm_pkg::CMD_FILTER_BYTE:
            begin
                if (flt_closed)
                begin
                    flt_closed = 1'b0;
                    flt_len    = 0;
                    flt_ovf    = 1'b0;
                end
                if (flt_len < FMAX)
                begin
                    flt_bytes[flt_len] = b;
                    flt_len++;
                end
                else
                    flt_ovf = 1'b1;
                flt_cur   = 0;
                lvl_mode  = LVL_COMPARE;
                lvl_start = 1'b1;
            end
            tfm_pkg::CMD_END_FILTER:
            begin
                flt_closed = 1'b1;
                restart_match();
            end
            tfm_pkg::CMD_TOPIC_BYTE:
            begin
                if (flt_closed)
                    take_topic_byte(b);
            end
            default:
            begin
                has_verdict       = 1'b1;
                v.matched         = flt_closed && !flt_ovf && topic_matches();
                v.filter_overflow = flt_ovf;
                if (flt_closed)
                    restart_match();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    step_row_t dir_table [DIR_ROWS] = '{
        // Nothing loaded yet: the filter is still open.
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b1, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  8'hFF,             8'd1,  1'b0, 1'b0, 1'b0},
        // Closing with no bytes gives the empty filter.
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b1, 1'b1, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  "a",               8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b1, 1'b0, 1'b0},
        // Filter "+/#": one-level wildcard, then multi-level with parent match.
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_PLUS,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_SLASH, 8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_HASH,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  "x",               8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  tfm_pkg::CH_SLASH, 8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  tfm_pkg::CH_SLASH, 8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  "b",               8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        // Wildcards inside a level compare literally.
        '{tfm_pkg::CMD_FILTER_BYTE, "a",               8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_HASH,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_PLUS,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  "a",               8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  tfm_pkg::CH_HASH,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  tfm_pkg::CH_PLUS,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        // A filter that fills the store exactly.
        '{tfm_pkg::CMD_FILTER_BYTE, 8'hFF,             8'd64, 1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  8'hFF,             8'd64, 1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        // One byte too many: overflow, both while open and after closing.
        '{tfm_pkg::CMD_FILTER_BYTE, 8'h00,             8'd65, 1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b1, 1'b0, 1'b1},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b1, 1'b0, 1'b1},
        // A new filter clears the overflow flag.
        '{tfm_pkg::CMD_FILTER_BYTE, tfm_pkg::CH_HASH,  8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_FILTER,  8'h00,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_TOPIC_BYTE,  8'h80,             8'd1,  1'b0, 1'b0, 1'b0},
        '{tfm_pkg::CMD_END_TOPIC,   8'h00,             8'd1,  1'b0, 1'b0, 1'b0}
    };

    task automatic offer(tfm_pkg::cmd_t c, logic [7:0] b);
        offers.push_back('{c, b, 1'b0, 1'b0, 1'b0, gen_phase[1:0]});
    endtask

    // Mostly a small alphabet so that topics agree with filters, with stray
    // wildcards and fully random bytes mixed in.
    function automatic logic [7:0] level_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return "a";
        if (r < 60)
            return "b";
        if (r < 70)
            return tfm_pkg::CH_PLUS;
        if (r < 80)
            return tfm_pkg::CH_HASH;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        b = level_byte();
        return (b == tfm_pkg::CH_SLASH) ? 8'("c") : b;
    endfunction

    task automatic draft_filter();
        int unsigned r;
        int unsigned nlev;
        int unsigned k;
        flt_draft.delete();
        r = $urandom_range(0, 99);
        if (r < 2)
            repeat (FMAX) flt_draft.push_back(level_byte());
        else if (r < 4)
            repeat ($urandom_range(FMAX + 1, FMAX + 6)) flt_draft.push_back(level_byte());
        else
        begin
            nlev = $urandom_range(1, 4);
            for (int i = 0; i < nlev; i++)
            begin
                if (i > 0)
                    flt_draft.push_back(tfm_pkg::CH_SLASH);
                k = $urandom_range(0, 99);
                if (i == nlev - 1 && k < 15)
                    flt_draft.push_back(tfm_pkg::CH_HASH);
                else if (k < 40)
                    flt_draft.push_back(tfm_pkg::CH_PLUS);
                else
                    repeat ($urandom_range(0, 3)) flt_draft.push_back(level_byte());
            end
        end
    endtask

    // Build a topic that follows the drafted filter level by level, then maybe
    // damage it so that near misses are common too.
    task automatic offer_topic_like_filter();
        int i;
        int j;
        int n;
        topic_draft.delete();
        i = 0;
        while (i < flt_draft.size())
        begin
            j = i;
            while (j < flt_draft.size() && flt_draft[j] != tfm_pkg::CH_SLASH)
                j++;
            if (j - i == 1 && flt_draft[i] == tfm_pkg::CH_PLUS)
                repeat ($urandom_range(0, 3)) topic_draft.push_back(name_byte());
            else if (j - i == 1 && flt_draft[i] == tfm_pkg::CH_HASH && j == flt_draft.size())
            begin
                n = $urandom_range(0, 2);
                if (n == 0 && topic_draft.size() > 0 && topic_draft[$] == tfm_pkg::CH_SLASH)
                    void'(topic_draft.pop_back());
                for (int l = 0; l < n; l++)
                begin
                    if (l > 0)
                        topic_draft.push_back(tfm_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 2)) topic_draft.push_back(name_byte());
                end
            end
            else
                for (int s = i; s < j; s++)
                    topic_draft.push_back(flt_draft[s]);
            if (j < flt_draft.size())
                topic_draft.push_back(tfm_pkg::CH_SLASH);
            i = j + 1;
        end
        if ($urandom_range(0, 99) < 25 && topic_draft.size() > 0)
            topic_draft[$urandom_range(0, topic_draft.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 10)
            topic_draft.push_back(level_byte());
        foreach (topic_draft[t])
            offer(tfm_pkg::CMD_TOPIC_BYTE, topic_draft[t]);
        offer(tfm_pkg::CMD_END_TOPIC, 8'($urandom_range(0, 255)));
    endtask

    task automatic build_stimulus();
        int dir_n;
        gen_phase = 0;
        for (int r = 0; r < DIR_ROWS; r++)
            repeat (dir_table[r].reps)
                offers.push_back('{dir_table[r].cmd, dir_table[r].ch, dir_table[r].typed,
                                   dir_table[r].t_matched, dir_table[r].t_overflow, 2'd0});
        dir_n = offers.size();
        // Random sessions: load a filter, close it, stream a few topics against it.
        while (offers.size() < dir_n + RAND_ITEMS)
        begin
            gen_phase = (offers.size() - dir_n) * 3 / RAND_ITEMS;
            if (gen_phase > 2)
                gen_phase = 2;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(1, 5))
                    offer(tfm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            draft_filter();
            foreach (flt_draft[f])
            begin
                // Now and then a topic transfer slips in while the filter is open.
                if ($urandom_range(0, 29) == 0)
                    offer($urandom_range(0, 1) ? tfm_pkg::CMD_TOPIC_BYTE
                                               : tfm_pkg::CMD_END_TOPIC,
                          8'($urandom_range(0, 255)));
                offer(tfm_pkg::CMD_FILTER_BYTE, flt_draft[f]);
            end
            offer(tfm_pkg::CMD_END_FILTER, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                offer(tfm_pkg::CMD_END_FILTER, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 5))
            begin
                if ($urandom_range(0, 99) < 85)
                    offer_topic_like_filter();
                else
                begin
                    repeat ($urandom_range(0, 6))
                        offer(tfm_pkg::CMD_TOPIC_BYTE, 8'($urandom_range(0, 255)));
                    offer(tfm_pkg::CMD_END_TOPIC, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Item channel: the driver also scores each accepted transfer, since it
    // knows which offer was on the wires at that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit       has_v;
        verdict_t v;
        int       pct;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                n_items++;
                match_step(cur_offer.cmd, cur_offer.ch, has_v, v);
                if (cur_offer.typed)
                    v = '{cur_offer.t_matched, cur_offer.t_overflow};
                if (has_v)
                    pending_verdicts.push_back(v);
            end
            // The wires are free once the current offer is taken or nothing is offered.
            if (!item.valid || item.ready)
            begin
                if (offers.size() > 0)
                begin
                    idle_phase = offers[0].phase;
                    pct = (idle_phase == 0) ? 17 : (idle_phase == 1) ? 51 : 0;
                end
                if (offers.size() > 0 && !roll(pct))
                begin
                    cur_offer = offers.pop_front();
                    item.valid <= 1'b1;
                    item.cmd   <= cur_offer.cmd;
                    item.ch    <= cur_offer.ch;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result channel: compare each transfer with the oldest expected verdict.
    // At every change of idling phase the receiver holds off for a long
    // stretch so that the result buffer fills and the item channel stalls.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t v;
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                n_results++;
                if (pending_verdicts.size() == 0)
                begin
                    $error("result transfer with no verdict pending: matched %0d overflow %0d",
                           result.matched, result.filter_overflow);
                    err_count++;
                end
                else
                begin
                    v = pending_verdicts.pop_front();
                    n_matches   += v.matched;
                    n_overflows += v.filter_overflow;
                    if (result.matched !== v.matched)
                    begin
                        $error("matched: expected %0d, actual %0d", v.matched, result.matched);
                        err_count++;
                    end
                    if (result.filter_overflow !== v.filter_overflow)
                    begin
                        $error("filter_overflow: expected %0d, actual %0d",
                               v.filter_overflow, result.filter_overflow);
                        err_count++;
                    end
                end
            end
            if (idle_phase != last_phase)
            begin
                last_phase = idle_phase;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= !roll((idle_phase == 0) ? 51 : (idle_phase == 1) ? 17 : 0);
        end
    end

    // Watchdog: count cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (result.valid && result.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.cmd     = tfm_pkg::CMD_FILTER_BYTE;
        item.ch      = 8'h00;
        result.ready = 1'b0;
        idle_phase   = 0;
        last_phase   = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        err_count    = 0;
        n_items      = 0;
        n_results    = 0;
        n_matches    = 0;
        n_overflows  = 0;
        // Predictor reset state.
        foreach (flt_bytes[i])
            flt_bytes[i] = 8'h00;
        flt_len    = 0;
        flt_cur    = 0;
        lvl_mode   = LVL_COMPARE;
        lvl_start  = 1'b1;
        flt_ovf    = 1'b0;
        flt_closed = 1'b0;

        build_stimulus();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every offer taken, then every verdict returned, then a short
        // quiet period to catch any stray result transfer.
        while (offers.size() > 0 || item.valid)
            @(posedge clk);
        while (pending_verdicts.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d item transfers and %0d result transfers", n_items, n_results);
        $display("Verdicts: %0d topic matches, %0d filter overflows", n_matches, n_overflows);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
